// File: rtl/clock_anomaly_monitor_defines.svh
// Assertion macros shared by the clock anomaly monitor checker.
// Needs nothing else; include it by its bare file name.
`ifndef CLOCK_ANOMALY_MONITOR_DEFINES_SVH
`define CLOCK_ANOMALY_MONITOR_DEFINES_SVH

// Checked only while the block is out of reset.
`define CAM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CAM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/cam_pkg.sv
// Types and constants of the clock anomaly monitor.
// Used by cam_check, clock_anomaly_monitor and cam_checker; depends on nothing.
package cam_pkg;

  typedef enum logic [2:0] {
    AN_OK        = 3'd0,
    AN_BACK      = 3'd1,
    AN_FWD       = 3'd2,
    AN_REGRESS   = 3'd3,
    AN_INCONS    = 3'd4,
    AN_SYNC_LOST = 3'd5
  } anomaly_e;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_SYNC   = 1'b1;

  localparam int unsigned ADDR_W = 3;
  localparam logic REG_FWD_LIMIT  = 1'b0;
  localparam logic REG_BACK_LIMIT = 1'b1;

  localparam logic [31:0] FWD_LIMIT_RESET  = 32'(5 * 60 * 1000);
  localparam logic [31:0] BACK_LIMIT_RESET = 32'd1000;

  typedef struct packed {
    logic        command;
    logic [63:0] mono_ms;
    logic [63:0] wall_ms;
    logic        sync_present;
  } in_t;

  typedef struct packed {
    logic [2:0]  anomaly;
    logic [31:0] regression_count;
    logic [31:0] jump_count;
    logic [31:0] loss_count;
  } out_t;

  // Verdict on one item and the state updates that follow from it.
  typedef struct packed {
    anomaly_e anomaly;
    logic     take_mono;
    logic     take_wall;
    logic     inc_regress;
    logic     inc_jump;
    logic     inc_loss;
  } dec_t;

endpackage

// File: rtl/clock_anomaly_monitor.sv
// Top level of the clock anomaly monitor: handshake stages, state and APB registers.
// Depends on cam_pkg and cam_check.
//
//  channel | direction | payload | transfer when
//  --------+-----------+---------+------------------------------------------
//  in      | input     | in_t    | in_valid_i && in_ready_o at clk_i rise
//  out     | output    | out_t   | out_valid_o && out_ready_i at clk_i rise
//  apb     | input     | 32 bit  | psel && penable && pwrite (pready high)
//
// One item is taken per cycle while the output does not stall; its result passes from the
// input register to the result register and is offered once it is in the result register.
// The rate is set by the state loop: the baselines are compared and updated
// in the same cycle, so the next item always sees the previous item's state.
// Reset clears the baselines, counters and valid flags and restores the limits.
// A stalled output holds its result; input ready drops only when both registers are full.
module clock_anomaly_monitor import cam_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_t              out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  // Configuration registers.
  logic [31:0] fwd_limit_q;
  logic [31:0] back_limit_q;
  logic        cfg_write;
  logic        cfg_index;

  // Handshake stages.
  logic s1_valid_q, s1_valid_d;
  in_t  s1_q;
  logic out_valid_q, out_valid_d;
  out_t out_q;
  logic s1_go;
  logic s1_fire;

  // Monitor state.
  logic                   had_sample_q, had_sample_d;
  logic                   sync_q, sync_d;
  logic [63:0]            base_mono_q, base_mono_d;
  logic [63:0]            base_wall_q, base_wall_d;
  logic [COUNT_WIDTH-1:0] regress_q, regress_d;
  logic [COUNT_WIDTH-1:0] jump_q, jump_d;
  logic [COUNT_WIDTH-1:0] loss_q, loss_d;

  dec_t dec;

  // The APB port never inserts wait states. The register index is the word
  // address bit; the byte offset bits are not decoded.
  assign pready    = 1'b1;
  assign cfg_index = paddr[2];
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (cfg_index == REG_BACK_LIMIT) ? back_limit_q : fwd_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_limit_q  <= FWD_LIMIT_RESET;
      back_limit_q <= BACK_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FWD_LIMIT:  fwd_limit_q  <= pwdata;
        REG_BACK_LIMIT: back_limit_q <= pwdata;
        default:        fwd_limit_q  <= fwd_limit_q;
      endcase
    end
  end

  // The input stage moves on whenever the result register is free or is being
  // emptied in this cycle.
  assign s1_go      = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && s1_go;
  assign in_ready_o = !s1_valid_q || s1_go;

  assign s1_valid_d  = in_ready_o ? in_valid_i : s1_valid_q;
  assign out_valid_d = s1_go ? s1_valid_q : out_valid_q;

  cam_check u_check (
    .item_i       (s1_q),
    .base_mono_i  (base_mono_q),
    .base_wall_i  (base_wall_q),
    .had_sample_i (had_sample_q),
    .sync_flag_i  (sync_q),
    .fwd_limit_i  (fwd_limit_q),
    .back_limit_i (back_limit_q),
    .dec_o        (dec)
  );

  // State updates take effect only when the item in the input register moves on.
  always_comb begin
    had_sample_d = had_sample_q;
    sync_d       = sync_q;
    base_mono_d  = base_mono_q;
    base_wall_d  = base_wall_q;
    regress_d    = regress_q;
    jump_d       = jump_q;
    loss_d       = loss_q;
    if (s1_fire) begin
      if (s1_q.command == CMD_SAMPLE) begin
        had_sample_d = 1'b1;
      end else begin
        sync_d = s1_q.sync_present;
      end
      if (dec.take_mono) begin
        base_mono_d = s1_q.mono_ms;
      end
      if (dec.take_wall) begin
        base_wall_d = s1_q.wall_ms;
      end
      // The counters stick at their maximum.
      if (dec.inc_regress && regress_q != CountMax) begin
        regress_d = regress_q + 1'b1;
      end
      if (dec.inc_jump && jump_q != CountMax) begin
        jump_d = jump_q + 1'b1;
      end
      if (dec.inc_loss && loss_q != CountMax) begin
        loss_d = loss_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      had_sample_q <= 1'b0;
      sync_q       <= 1'b1;
      base_mono_q  <= '0;
      base_wall_q  <= '0;
      regress_q    <= '0;
      jump_q       <= '0;
      loss_q       <= '0;
    end else begin
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
      had_sample_q <= had_sample_d;
      sync_q       <= sync_d;
      base_mono_q  <= base_mono_d;
      base_wall_q  <= base_wall_d;
      regress_q    <= regress_d;
      jump_q       <= jump_d;
      loss_q       <= loss_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_data_i;
    end
    if (s1_fire) begin
      out_q.anomaly          <= dec.anomaly;
      out_q.regression_count <= 32'(regress_d);
      out_q.jump_count       <= 32'(jump_d);
      out_q.loss_count       <= 32'(loss_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/cam_check.sv
// Classification of one item against the stored baselines and limits.
// Depends on cam_pkg; purely combinational.
module cam_check import cam_pkg::*; (
  input  in_t         item_i,
  input  logic [63:0] base_mono_i,
  input  logic [63:0] base_wall_i,
  input  logic        had_sample_i,
  input  logic        sync_flag_i,
  input  logic [31:0] fwd_limit_i,
  input  logic [31:0] back_limit_i,
  output dec_t        dec_o
);

  logic [64:0] fwd_sum;
  logic [64:0] back_sum;
  logic [64:0] wall_ext;
  logic [64:0] base_wall_ext;
  logic        back_jump;
  logic        fwd_jump;

  // Sums are kept at 65 bits so that they never wrap.
  assign wall_ext      = {1'b0, item_i.wall_ms};
  assign base_wall_ext = {1'b0, base_wall_i};
  assign fwd_sum       = base_wall_ext + {33'd0, fwd_limit_i};
  assign back_sum      = wall_ext + {33'd0, back_limit_i};
  assign back_jump     = back_sum < base_wall_ext;
  assign fwd_jump      = wall_ext > fwd_sum;

  always_comb begin
    dec_o = '{anomaly: AN_OK, default: 1'b0};
    if (item_i.command == CMD_SAMPLE) begin
      if (had_sample_i) begin
        priority if (item_i.mono_ms < base_mono_i) begin
          dec_o.anomaly     = AN_REGRESS;
          dec_o.inc_regress = 1'b1;
        end else if (back_jump) begin
          dec_o.anomaly  = AN_BACK;
          dec_o.inc_jump = 1'b1;
        end else if (fwd_jump) begin
          dec_o.anomaly  = AN_FWD;
          dec_o.inc_jump = 1'b1;
        end else if (item_i.wall_ms != base_wall_i && item_i.mono_ms == base_mono_i) begin
          dec_o.anomaly  = AN_INCONS;
          dec_o.inc_jump = 1'b1;
        end else begin
          dec_o.anomaly = AN_OK;
        end
      end
      if (dec_o.anomaly == AN_OK) begin
        dec_o.take_mono = 1'b1;
        dec_o.take_wall = 1'b1;
      end else if (item_i.mono_ms > base_mono_i) begin
        // Anomalous but forward-moving: wall follows only within the forward limit.
        dec_o.take_mono = 1'b1;
        dec_o.take_wall = (item_i.wall_ms > base_wall_i) && (wall_ext < fwd_sum);
      end
    end else begin
      if (sync_flag_i && !item_i.sync_present) begin
        dec_o.anomaly  = AN_SYNC_LOST;
        dec_o.inc_loss = 1'b1;
      end
    end
  end

endmodule

// File: rtl/cam_checker.sv
// Port-level checks of the clock anomaly monitor, bound to its top level.
// Depends on cam_pkg and clock_anomaly_monitor_defines.svh.
`include "clock_anomaly_monitor_defines.svh"

module cam_checker import cam_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // A result waiting for the consumer must not change or vanish.
  property p_out_hold;
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o);
  endproperty

  // Only the six defined verdicts are ever reported.
  property p_code_range;
    out_valid_o |-> out_data_o.anomaly <= AN_SYNC_LOST;
  endproperty

  // The input is held off only when a result is backed up at the output.
  property p_stall_cause;
    in_valid_i && !in_ready_o |-> out_valid_o && !out_ready_i;
  endproperty

  `CAM_ASSERT(a_out_hold, clk_i, rst_ni, p_out_hold, "output changed while stalled")
  `CAM_ASSERT(a_code_range, clk_i, rst_ni, p_code_range, "undefined anomaly code")
  `CAM_ASSERT(a_stall_cause, clk_i, rst_ni, p_stall_cause, "input stalled without backpressure")

  // Nothing is offered while reset is applied.
  `CAM_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

bind clock_anomaly_monitor cam_checker u_cam_checker (.*);
